// ----- rtl/core/limit_order_book_matcher_assert.svh -----
// Assertion macros for the checker file of the order book matcher.
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OBM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define OBM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/obmatch_pkg.sv -----
// Types and codes shared by the order book matcher modules.
package obmatch_pkg;

  typedef enum logic [2:0] {
    KIND_TRADE      = 3'd0,
    KIND_RESTED     = 3'd1,
    KIND_NOT_RESTED = 3'd2,
    KIND_FULL       = 3'd3,
    KIND_DUP_ID     = 3'd4,
    KIND_CANCELLED  = 3'd5,
    KIND_NOT_FOUND  = 3'd6
  } kind_e;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_CANCEL = 1'b1;
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic        side;
    logic [15:0] limit_price;
    logic [31:0] quantity;
    logic [31:0] order_id;
  } in_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] resting_id;
    logic [31:0] aggressor_id;
    logic [15:0] fill_price;
    logic [31:0] fill_quantity;
    logic [31:0] left_quantity;
    logic        last;
  } out_word_t;

  // Classified command; the limit is held at the widest supported price width.
  typedef struct packed {
    logic        is_cancel;
    logic        side;
    logic [31:0] limit;
    logic [31:0] quantity;
    logic [31:0] order_id;
  } cmd_t;

endpackage

// ----- rtl/core/obmatch_front.sv -----
// Front end: takes input words, classifies them and forwards commands.
module obmatch_front #(
  parameter int PRICE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  obmatch_pkg::in_word_t in_word_i,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i,
  output obmatch_pkg::cmd_t     cmd_o
);

  localparam logic [31:0] PriceMask = 32'((64'd1 << PRICE_BITS) - 64'd1);

  logic              hold_v_q;
  obmatch_pkg::cmd_t hold_q;
  logic              take;

  assign in_stall_o  = hold_v_q && !cmd_ready_i;
  assign take        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = hold_v_q;
  assign cmd_o       = hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
    end else if (take) begin
      hold_v_q <= 1'b1;
    end else if (cmd_ready_i) begin
      hold_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      hold_q.is_cancel <= (in_word_i.opcode == obmatch_pkg::OP_CANCEL);
      hold_q.side      <= in_word_i.side;
      hold_q.limit     <= {16'd0, in_word_i.limit_price} & PriceMask;
      hold_q.quantity  <= in_word_i.quantity;
      hold_q.order_id  <= in_word_i.order_id;
    end
  end

endmodule

// ----- rtl/core/obmatch_fifo.sv -----
// Two-entry command queue between the front end and the matching engine.
module obmatch_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              ready_o,
  input  obmatch_pkg::cmd_t data_i,
  output logic              valid_o,
  input  logic              pop_i,
  output obmatch_pkg::cmd_t data_o
);

  obmatch_pkg::cmd_t slot_q [2];
  logic              wr_q;
  logic              rd_q;
  logic [1:0]        cnt_q;
  logic              do_push;
  logic              do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/obmatch_back.sv -----
// Matching engine: scans the order store, emits trades and status words.
module obmatch_back #(
  parameter int MAX_ORDERS = 32,
  parameter int PRICE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  input  obmatch_pkg::cmd_t      cmd_i,
  output logic                   cmd_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output obmatch_pkg::out_word_t out_word_o
);

  localparam int IdxW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
  localparam int CntW = $clog2(MAX_ORDERS + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(MAX_ORDERS);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE} state_e;
  typedef enum logic [2:0] {
    D_DUP, D_CANCEL, D_NOT_FOUND, D_NOT_RESTED, D_FILL, D_REST, D_FULL
  } dec_e;

  // Order store, one array per field.
  logic                  side_mem  [MAX_ORDERS];
  logic [PRICE_BITS-1:0] price_mem [MAX_ORDERS];
  logic [31:0]           qty_mem   [MAX_ORDERS];
  logic [31:0]           id_mem    [MAX_ORDERS];
  logic [31:0]           stamp_mem [MAX_ORDERS];
  logic [MAX_ORDERS-1:0] valid_q;

  state_e            state_q;
  obmatch_pkg::cmd_t cmd_q;
  logic [31:0]       qty_q;
  logic              first_q;
  logic [31:0]       arrival_q;
  logic [CntW-1:0]   idx_q;

  logic                  rd_en_q;
  logic [IdxW-1:0]       rd_idx_q;
  logic                  rd_valid_q;
  logic                  rd_side_q;
  logic [PRICE_BITS-1:0] rd_price_q;
  logic [31:0]           rd_qty_q;
  logic [31:0]           rd_id_q;
  logic [31:0]           rd_stamp_q;

  logic                  hit_q;
  logic [IdxW-1:0]       hit_idx_q;
  logic                  free_found_q;
  logic [IdxW-1:0]       free_idx_q;
  logic                  best_found_q;
  logic [IdxW-1:0]       best_idx_q;
  logic [PRICE_BITS-1:0] best_price_q;
  logic [31:0]           best_qty_q;
  logic [31:0]           best_id_q;
  logic [31:0]           best_age_q;

  logic                   out_valid_q;
  obmatch_pkg::out_word_t out_q;

  logic [IdxW-1:0]       scan_idx;
  logic [PRICE_BITS-1:0] lim;
  logic [31:0]           rd_age;
  logic                  is_cand;
  logic                  better;
  logic                  out_free;
  logic                  load_out;
  logic [31:0]           trade_qty;
  logic [31:0]           bp32;
  dec_e                  dec;
  obmatch_pkg::out_word_t res;
  logic                  we_all;
  logic                  we_qty;
  logic [IdxW-1:0]       w_idx;

  assign scan_idx  = idx_q[IdxW-1:0];
  assign lim       = cmd_q.limit[PRICE_BITS-1:0];
  assign rd_age    = arrival_q - rd_stamp_q;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign load_out  = (state_q == S_DECIDE) && out_free;
  assign trade_qty = (qty_q < best_qty_q) ? qty_q : best_qty_q;
  assign bp32      = 32'(best_price_q);

  // Crossing opposite-side entries; better is best price, then oldest.
  always_comb begin
    is_cand = rd_valid_q && (rd_side_q != cmd_q.side);
    if (cmd_q.side == obmatch_pkg::SIDE_BUY) begin
      is_cand = is_cand && (rd_price_q <= lim);
    end else begin
      is_cand = is_cand && (rd_price_q >= lim);
    end
    if (!best_found_q) begin
      better = 1'b1;
    end else if (rd_price_q != best_price_q) begin
      better = (cmd_q.side == obmatch_pkg::SIDE_BUY) ? (rd_price_q < best_price_q)
                                                     : (rd_price_q > best_price_q);
    end else begin
      better = rd_age > best_age_q;
    end
  end

  always_comb begin
    if (cmd_q.is_cancel) begin
      dec = hit_q ? D_CANCEL : D_NOT_FOUND;
    end else if (first_q && hit_q) begin
      dec = D_DUP;
    end else if (qty_q == 32'd0) begin
      dec = D_NOT_RESTED;
    end else if (best_found_q) begin
      dec = D_FILL;
    end else if (free_found_q) begin
      dec = D_REST;
    end else begin
      dec = D_FULL;
    end
  end

  always_comb begin
    res               = '0;
    res.aggressor_id  = cmd_q.order_id;
    res.last          = 1'b1;
    case (dec)
      D_FILL: begin
        res.kind          = obmatch_pkg::KIND_TRADE;
        res.resting_id    = best_id_q;
        res.fill_price    = bp32[15:0];
        res.fill_quantity = trade_qty;
        res.last          = 1'b0;
      end
      D_DUP: begin
        res.kind          = obmatch_pkg::KIND_DUP_ID;
        res.left_quantity = qty_q;
      end
      D_CANCEL:     res.kind = obmatch_pkg::KIND_CANCELLED;
      D_NOT_FOUND:  res.kind = obmatch_pkg::KIND_NOT_FOUND;
      D_NOT_RESTED: res.kind = obmatch_pkg::KIND_NOT_RESTED;
      D_REST: begin
        res.kind          = obmatch_pkg::KIND_RESTED;
        res.left_quantity = qty_q;
      end
      D_FULL: begin
        res.kind          = obmatch_pkg::KIND_FULL;
        res.left_quantity = qty_q;
      end
      default: res.kind = obmatch_pkg::KIND_NOT_FOUND;
    endcase
  end

  assign we_all    = load_out && (dec == D_REST);
  assign we_qty    = load_out && ((dec == D_REST) || (dec == D_FILL));
  assign w_idx     = (dec == D_REST) ? free_idx_q : best_idx_q;
  assign cmd_pop_o = load_out && (dec != D_FILL);

  always_ff @(posedge clk_i) begin
    if (we_all) begin
      side_mem[w_idx]  <= cmd_q.side;
      price_mem[w_idx] <= lim;
      id_mem[w_idx]    <= cmd_q.order_id;
      stamp_mem[w_idx] <= arrival_q;
    end
    if (we_qty) begin
      qty_mem[w_idx] <= (dec == D_REST) ? qty_q : (best_qty_q - trade_qty);
    end
    rd_side_q  <= side_mem[scan_idx];
    rd_price_q <= price_mem[scan_idx];
    rd_qty_q   <= qty_mem[scan_idx];
    rd_id_q    <= id_mem[scan_idx];
    rd_stamp_q <= stamp_mem[scan_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      valid_q      <= '0;
      arrival_q    <= 32'd0;
      out_valid_q  <= 1'b0;
      rd_en_q      <= 1'b0;
      rd_valid_q   <= 1'b0;
      idx_q        <= '0;
      first_q      <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q        <= cmd_i;
            qty_q        <= cmd_i.quantity;
            first_q      <= 1'b1;
            idx_q        <= '0;
            rd_en_q      <= 1'b0;
            hit_q        <= 1'b0;
            free_found_q <= 1'b0;
            best_found_q <= 1'b0;
            state_q      <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_en_q    <= (idx_q != LastCnt);
          rd_idx_q   <= scan_idx;
          rd_valid_q <= valid_q[scan_idx];
          if (idx_q != LastCnt) begin
            idx_q <= idx_q + CntW'(1);
          end
          if (rd_en_q) begin
            if (rd_valid_q && (rd_id_q == cmd_q.order_id)) begin
              hit_q     <= 1'b1;
              hit_idx_q <= rd_idx_q;
            end
            if (!rd_valid_q && !free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= rd_idx_q;
            end
            if (is_cand && better) begin
              best_found_q <= 1'b1;
              best_idx_q   <= rd_idx_q;
              best_price_q <= rd_price_q;
              best_qty_q   <= rd_qty_q;
              best_id_q    <= rd_id_q;
              best_age_q   <= rd_age;
            end
          end else if (idx_q == LastCnt) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            out_q   <= res;
            state_q <= (dec == D_FILL) ? S_SCAN : S_IDLE;
            case (dec)
              D_FILL: begin
                qty_q <= qty_q - trade_qty;
                if (trade_qty == best_qty_q) begin
                  valid_q[best_idx_q] <= 1'b0;
                end
                first_q      <= 1'b0;
                idx_q        <= '0;
                rd_en_q      <= 1'b0;
                hit_q        <= 1'b0;
                free_found_q <= 1'b0;
                best_found_q <= 1'b0;
              end
              D_CANCEL: valid_q[hit_idx_q] <= 1'b0;
              D_REST: begin
                valid_q[free_idx_q] <= 1'b1;
                arrival_q           <= arrival_q + 32'd1;
              end
              default: ;
            endcase
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ----- rtl/core/limit_order_book_matcher.sv -----
// Top level of the price-time priority order book matcher.
//
//   Channel  Dir  Handshake              Word
//   in       in   in_valid_i/in_stall_o  obmatch_pkg::in_word_t (add or cancel)
//   out      out  out_valid_o/out_stall_i obmatch_pkg::out_word_t (trade/status)
//
// Each pass over the store reads one entry per cycle from the store's single read
// port and ends in a decision state that waits while the output word is stalled.
// In the engine an add with F fills makes F + 1 passes and a cancel makes one.
// Reset clears the entry valid bits, the arrival counter and the control state,
// not the stored fields, so the block takes input as soon as reset is released.
// The front end and a two-word queue keep taking input while the engine waits on
// a stalled output, until they are full.
module limit_order_book_matcher #(
  parameter int MAX_ORDERS = 32,
  parameter int PRICE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  obmatch_pkg::in_word_t  in_word_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output obmatch_pkg::out_word_t out_word_o
);

  // Front end to queue.
  logic              f_valid;
  logic              f_ready;
  obmatch_pkg::cmd_t f_cmd;

  // Queue to matching engine.
  logic              q_valid;
  logic              q_pop;
  obmatch_pkg::cmd_t q_cmd;

  // The front end masks the limit to the configured price width and decodes
  // the opcode; it holds one word and stalls only when the queue is full.
  obmatch_front #(
    .PRICE_BITS(PRICE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .cmd_valid_o(f_valid),
    .cmd_ready_i(f_ready),
    .cmd_o      (f_cmd)
  );

  obmatch_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_valid),
    .ready_o(f_ready),
    .data_i (f_cmd),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .data_o (q_cmd)
  );

  // The engine pops a command only as its final status word is loaded
  // into the output register.
  obmatch_back #(
    .MAX_ORDERS(MAX_ORDERS),
    .PRICE_BITS(PRICE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (q_cmd),
    .cmd_pop_o  (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule

// ----- rtl/core/obmatch_checker.sv -----
// Port-level checks on the order book matcher and their binding.
`include "limit_order_book_matcher_assert.svh"

module obmatch_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input obmatch_pkg::out_word_t out_word_o
);

  `OBM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o), "stalled output word changed")
  `OBM_ASSERT_IMP(a_trade_not_last, clk_i, rst_ni, out_valid_o && (out_word_o.kind == obmatch_pkg::KIND_TRADE), !out_word_o.last && (out_word_o.fill_quantity != 32'd0), "trade word is last or empty")
  `OBM_ASSERT_IMP(a_status_last, clk_i, rst_ni, out_valid_o && (out_word_o.kind != obmatch_pkg::KIND_TRADE), out_word_o.last && (out_word_o.resting_id == 32'd0), "status word malformed")
  `OBM_ASSERT_IMP(a_status_no_fill, clk_i, rst_ni, out_valid_o && out_word_o.last, (out_word_o.fill_price == 16'd0) && (out_word_o.fill_quantity == 32'd0), "status word carries a fill")

endmodule

bind limit_order_book_matcher obmatch_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_o (out_word_o)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the price-time priority order book matcher.
`timescale 1ns / 1ps

module tb_top;

  localparam int BOOK_DEPTH  = 32;
  localparam int STALL_LIMIT = 20000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  obmatch_pkg::in_word_t  in_word_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  obmatch_pkg::out_word_t out_word_o;

  limit_order_book_matcher i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the resting order store, kept in step with every accepted word.
  logic        book_valid [BOOK_DEPTH];
  logic        book_side  [BOOK_DEPTH];
  logic [15:0] book_price [BOOK_DEPTH];
  logic [31:0] book_qty   [BOOK_DEPTH];
  logic [31:0] book_id    [BOOK_DEPTH];
  logic [31:0] book_stamp [BOOK_DEPTH];
  logic [31:0] arrivals;

  obmatch_pkg::out_word_t pending_reports[$];
  bit        failed = 1'b0;
  bit        quiet_in = 1'b0;   // When set, the sender inserts no gaps.
  bit        quiet_out = 1'b0;  // When set, the receiver draws no new stalls.
  int        idle_cycles = 0;

  function automatic obmatch_pkg::out_word_t report(obmatch_pkg::kind_e k,
                                                    logic [31:0] rid, logic [31:0] aid,
                                                    logic [15:0] px, logic [31:0] fq,
                                                    logic [31:0] left, logic fin);
    obmatch_pkg::out_word_t r;
    r.kind = k; r.resting_id = rid; r.aggressor_id = aid; r.fill_price = px;
    r.fill_quantity = fq; r.left_quantity = left; r.last = fin;
    return r;
  endfunction

  // Appends one expected word to the tail of the pending list.
  function automatic void queue_report(obmatch_pkg::out_word_t r);
    pending_reports = {pending_reports, r};
  endfunction

  function automatic int find_order(logic [31:0] id);
    for (int i = 0; i < BOOK_DEPTH; i++)
      if (book_valid[i] && book_id[i] == id) return i;
    return -1;
  endfunction

  // Best crossing order on the opposite side: best price first, then greatest age.
  function automatic int best_opposite(logic side, logic [15:0] lim);
    int best;
    logic better;
    best = -1;
    for (int i = 0; i < BOOK_DEPTH; i++) begin
      if (!book_valid[i] || book_side[i] == side) continue;
      if (side == obmatch_pkg::SIDE_BUY ? (book_price[i] > lim) : (book_price[i] < lim))
        continue;
      if (best < 0) begin
        best = i;
        continue;
      end
      if (book_price[i] != book_price[best])
        better = (side == obmatch_pkg::SIDE_BUY) ? (book_price[i] < book_price[best])
                                                 : (book_price[i] > book_price[best]);
      else
        better = (arrivals - book_stamp[i]) > (arrivals - book_stamp[best]);
      if (better) best = i;
    end
    return best;
  endfunction

  // Applies one accepted word to the shadow book and queues the reports it causes.
  function automatic void match_order(obmatch_pkg::in_word_t w);
    int          slot;
    int          fills;
    logic [31:0] qty;
    logic [31:0] fill;
    qty = w.quantity;
    fills = 0;
    if (w.opcode == obmatch_pkg::OP_CANCEL) begin
      slot = find_order(w.order_id);
      if (slot < 0) begin
        queue_report(report(obmatch_pkg::KIND_NOT_FOUND, '0, w.order_id, '0, '0, '0, 1'b1));
      end else begin
        book_valid[slot] = 1'b0;
        queue_report(report(obmatch_pkg::KIND_CANCELLED, '0, w.order_id, '0, '0, '0, 1'b1));
      end
      return;
    end
    if (find_order(w.order_id) >= 0) begin
      queue_report(report(obmatch_pkg::KIND_DUP_ID, '0, w.order_id, '0, '0, qty, 1'b1));
      return;
    end
    while (qty != 0 && fills < BOOK_DEPTH) begin
      slot = best_opposite(w.side, w.limit_price);
      if (slot < 0) break;
      fill = (qty < book_qty[slot]) ? qty : book_qty[slot];
      queue_report(report(obmatch_pkg::KIND_TRADE, book_id[slot], w.order_id,
                          book_price[slot], fill, '0, 1'b0));
      fills++;
      qty -= fill;
      book_qty[slot] -= fill;
      if (book_qty[slot] == 0) book_valid[slot] = 1'b0;
    end
    if (qty == 0) begin
      queue_report(report(obmatch_pkg::KIND_NOT_RESTED, '0, w.order_id, '0, '0, '0, 1'b1));
      return;
    end
    slot = -1;
    for (int i = BOOK_DEPTH - 1; i >= 0; i--)
      if (!book_valid[i]) slot = i;
    if (slot < 0) begin
      queue_report(report(obmatch_pkg::KIND_FULL, '0, w.order_id, '0, '0, qty, 1'b1));
      return;
    end
    book_valid[slot] = 1'b1;
    book_side[slot]  = w.side;
    book_price[slot] = w.limit_price;
    book_qty[slot]   = qty;
    book_id[slot]    = w.order_id;
    book_stamp[slot] = arrivals;
    arrivals++;
    queue_report(report(obmatch_pkg::KIND_RESTED, '0, w.order_id, '0, '0, qty, 1'b1));
  endfunction

  // Sends one word after a random gap. Valid is lowered only when a gap follows,
  // so back-to-back words never see valid dropped and raised in one time step.
  task automatic send_word(obmatch_pkg::in_word_t w);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    match_order(w);
  endtask

  function automatic obmatch_pkg::in_word_t add_word(logic side, logic [15:0] px,
                                                     logic [31:0] qty, logic [31:0] id);
    obmatch_pkg::in_word_t w;
    w.opcode = obmatch_pkg::OP_ADD; w.side = side; w.limit_price = px; w.quantity = qty;
    w.order_id = id;
    return w;
  endfunction

  function automatic obmatch_pkg::in_word_t cancel_word(logic [31:0] id);
    obmatch_pkg::in_word_t w;
    w = '0;
    w.opcode = obmatch_pkg::OP_CANCEL; w.order_id = id;
    w.side = 1'($urandom_range(0, 1)); w.limit_price = 16'($urandom);
    w.quantity = $urandom;
    return w;
  endfunction

  // Receiver: checks every accepted report and draws a new stall length after each.
  int stall_left = 0;
  always @(posedge clk_i) begin
    obmatch_pkg::out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %p", $time, out_word_o);
        failed = 1'b1;
      end else begin
        want = pending_reports[0];
        pending_reports.delete(0);
        if (out_word_o.kind != want.kind ||
            out_word_o.resting_id != want.resting_id ||
            out_word_o.aggressor_id != want.aggressor_id ||
            out_word_o.fill_price != want.fill_price ||
            out_word_o.fill_quantity != want.fill_quantity ||
            out_word_o.left_quantity != want.left_quantity ||
            out_word_o.last != want.last) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, want, out_word_o);
          failed = 1'b1;
        end
      end
      stall_left = quiet_out ? 0 : $urandom_range(0, 13);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left > 0);
  end

  // Watchdog: ends the run if neither channel moves a word for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("limit_order_book_matcher regression: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // Field extremes, both sides, every status except store full, every cancel outcome.
  task automatic test_directed();
    send_word(cancel_word(32'd7));                                          // unknown id
    send_word(add_word(obmatch_pkg::SIDE_BUY, 16'd0, 32'd0, 32'd1));        // zero quantity
    send_word(add_word(obmatch_pkg::SIDE_BUY, 16'd100, 32'd10, 32'd0));     // id zero rests
    send_word(add_word(obmatch_pkg::SIDE_BUY, 16'd100, 32'd5, 32'd2));      // same level
    send_word(add_word(obmatch_pkg::SIDE_BUY, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(add_word(obmatch_pkg::SIDE_SELL, 16'd100, 32'd3, 32'd0));     // duplicate id
    send_word(add_word(obmatch_pkg::SIDE_SELL, 16'd90, 32'd12, 32'd3));     // two fills
    send_word(add_word(obmatch_pkg::SIDE_SELL, 16'hFFFF, 32'd4, 32'd4));    // no cross
    send_word(add_word(obmatch_pkg::SIDE_SELL, 16'd200, 32'd6, 32'd5));
    send_word(add_word(obmatch_pkg::SIDE_BUY, 16'hFFFF, 32'd20, 32'd6));    // sweeps asks
    send_word(add_word(obmatch_pkg::SIDE_SELL, 16'd0, 32'd1, 32'd8));       // hits best bid
    send_word(cancel_word(32'hFFFF_FFFF));
    send_word(cancel_word(32'hFFFF_FFFF));                                  // already gone
    send_word(add_word(obmatch_pkg::SIDE_SELL, 16'd0, 32'hFFFF_FFFF, 32'd9)); // all bids
    send_word(cancel_word(32'd9));
  endtask

  // Fills the store, checks the full status, then sweeps every entry in one add.
  task automatic test_store_full();
    quiet_in = 1'b1;
    for (int i = 0; i < BOOK_DEPTH; i++)
      send_word(add_word(obmatch_pkg::SIDE_SELL, 16'(500 + (i % 4)), 32'(1 + i),
                         32'(1000 + i)));
    quiet_in = 1'b0;
    send_word(add_word(obmatch_pkg::SIDE_BUY, 16'd10, 32'd3, 32'd2000));  // store full
    // Takes all 32 resting orders, then the remainder rests.
    send_word(add_word(obmatch_pkg::SIDE_BUY, 16'hFFFF, 32'hFFFF_FFFF, 32'd2001));
    send_word(cancel_word(32'd2001));
  endtask

  // Mostly well-formed traffic around a narrow price band with a small id pool so
  // that crosses, duplicates and cancels are frequent; occasional wide values.
  task automatic test_random(int count);
    obmatch_pkg::in_word_t w;
    for (int n = 0; n < count; n++) begin
      quiet_in  = (n / 20) % 3 == 2;
      quiet_out = (n / 20) % 4 == 3;
      if ($urandom_range(0, 4) == 0) begin
        w = cancel_word($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 47));
      end else begin
        w = add_word(1'($urandom_range(0, 1)),
                     $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(100, 115)),
                     $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 20),
                     $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 47));
      end
      send_word(w);
      if (n == count / 2) wait_drained();  // sender holds off until all reports return
    end
    quiet_in = 1'b0;
    quiet_out = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < BOOK_DEPTH; i++) book_valid[i] = 1'b0;
    arrivals = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_store_full();
    test_random(70);
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (!failed && pending_reports.size() == 0)
      $display("limit_order_book_matcher regression: pass");
    else
      $display("limit_order_book_matcher regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/obmatch_pkg.sv
rtl/core/obmatch_front.sv
rtl/core/obmatch_fifo.sv
rtl/core/obmatch_back.sv
rtl/core/limit_order_book_matcher.sv
rtl/core/obmatch_checker.sv
tb/tb_top.sv
